### hw/rtl/lkv_pkg.sv
// Shared constants and types for the LRU key-value cache.
// Used by lkv_cell, lru_key_value_cache_top and the testbench; depends on nothing else.
package lkv_pkg;

	localparam int ENTRIES    = 16;
	localparam int KEY_BITS   = 16;
	localparam int VALUE_BITS = 16;
	localparam int CAP_BITS   = 5;
	localparam int CAP_RESET  = 16;

	// Index of one cell, and a count that can hold ENTRIES itself.
	localparam int IDX_W = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
	localparam int CNT_W = $clog2(ENTRIES + 1);

	// Operation codes carried in the input tuser.
	localparam logic ACT_GET = 1'b0;
	localparam logic ACT_PUT = 1'b1;

	// Contents of one cell of the recency chain.
	typedef struct packed {
		logic                  valid;
		logic [KEY_BITS-1:0]   key;
		logic [VALUE_BITS-1:0] value;
	} entry_t;

endpackage

### hw/rtl/lru_key_value_cache_top.sv
// Top level of the fully associative LRU key-value cache.
// Depends on lkv_pkg and lkv_cell.
//
// Usage:
// The request channel (s_*) carries one get or put per item: s_tuser[0] is the
// action (0 get, 1 put), s_tdata holds key in [15:0] and value in [31:16].
// The result channel (m_*) returns exactly one item per request: m_tuser[0] is
// found, m_tuser[1] is evicted, m_tdata holds read_value in [15:0] and
// evicted_key in [31:16].
// The entries sit in a row of cells ordered by recency, cell 0 most recent.
// A hit or insert moves its entry to cell 0 while the cells in front of it
// shift down by one place, so the least recent entry is always the last
// valid cell. The key compare runs in every cell in parallel.
// The result is registered, and one request is taken every cycle while the
// receiver keeps up, set by the single compare-and-shift step through the row.
// A request is accepted while the result register is empty or its item is
// being taken in the same cycle; a stalled receiver holds the result and
// stops the request side after one item. Reset clears all valid bits, the use
// count and sets capacity to 16. cfg_we writes capacity (cfg_wdata); the user
// asserts it only while the block is idle, which the block does not enforce.
module lru_key_value_cache_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [4:0]  cfg_wdata,   // capacity
	input  logic        s_tvalid,
	output logic        s_tready,
	input  logic [31:0] s_tdata,     // key [15:0], value [31:16]
	input  logic [0:0]  s_tuser,     // action [0]
	output logic        m_tvalid,
	input  logic        m_tready,
	output logic [31:0] m_tdata,     // read_value [15:0], evicted_key [31:16]
	output logic [1:0]  m_tuser      // found [0], evicted [1]
);

	localparam int N  = lkv_pkg::ENTRIES;
	localparam int KB = lkv_pkg::KEY_BITS;
	localparam int VB = lkv_pkg::VALUE_BITS;
	localparam int IW = lkv_pkg::IDX_W;
	localparam int CW = lkv_pkg::CNT_W;

	logic [lkv_pkg::CAP_BITS-1:0] cap_q;
	logic [CW-1:0]                used_q;

	logic          accept;
	logic          in_action;
	logic [KB-1:0] in_key;
	logic [VB-1:0] in_value;

	lkv_pkg::entry_t entries [N];
	lkv_pkg::entry_t lefts   [N];
	logic [N-1:0]    hit_vec;
	logic [N-1:0]    valid_vec;
	logic [N-1:0]    shift_vec;

	logic          any_hit;
	logic [IW-1:0] hit_idx;
	logic [VB-1:0] hit_value;
	logic [CW-1:0] eff_cap;
	logic          is_put;
	logic          need_evict;
	logic          do_update;
	logic [IW-1:0] victim_idx;
	logic [IW-1:0] boundary;

	logic          m_tvalid_q;
	logic          found_q;
	logic          evicted_q;
	logic [VB-1:0] read_value_q;
	logic [KB-1:0] evicted_key_q;

	assign in_action = s_tuser[0];
	assign in_key    = s_tdata[KB-1:0];
	assign in_value  = s_tdata[KB+VB-1:KB];
	assign s_tready  = !m_tvalid_q || m_tready;
	assign accept    = s_tvalid && s_tready;
	assign is_put    = (in_action == lkv_pkg::ACT_PUT);

	// The row of cells; each takes its left neighbor's entry on a shift.
	for (genvar g = 0; g < N; g++) begin : g_cell
		if (g == 0) begin : g_head
			assign lefts[g].valid = 1'b1;
			assign lefts[g].key   = in_key;
			assign lefts[g].value = is_put ? in_value : hit_value;
		end else begin : g_body
			assign lefts[g] = entries[g-1];
		end

		lkv_cell u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.shift      (shift_vec[g]),
			.left       (lefts[g]),
			.lookup_key (in_key),
			.entry      (entries[g]),
			.hit        (hit_vec[g])
		);

		assign valid_vec[g] = entries[g].valid;
	end

	// Encode the hit position and select the hit entry's value.
	always_comb begin
		hit_idx   = '0;
		hit_value = '0;
		for (int i = 0; i < N; i++) begin
			if (hit_vec[i]) begin
				hit_idx   = hit_idx | IW'(i);
				hit_value = hit_value | entries[i].value;
			end
		end
	end

	assign any_hit = |hit_vec;

	// A capacity of zero acts as one; above the entry count it saturates.
	always_comb begin
		if (cap_q == '0) begin
			eff_cap = CW'(1);
		end else if (int'(cap_q) > N) begin
			eff_cap = CW'(N);
		end else begin
			eff_cap = CW'(cap_q);
		end
	end

	// The least recent entry is the last valid cell.
	assign need_evict = is_put && !any_hit && (used_q >= eff_cap);
	assign victim_idx = IW'(used_q - CW'(1));
	assign do_update  = accept && (any_hit || is_put);

	// The shift reaches down to the hit cell, the victim, or the first free cell.
	always_comb begin
		priority if (any_hit) begin
			boundary = hit_idx;
		end else if (need_evict) begin
			boundary = victim_idx;
		end else begin
			boundary = IW'(used_q);
		end
		for (int i = 0; i < N; i++) begin
			shift_vec[i] = do_update && (IW'(i) <= boundary);
		end
	end

	// Capacity register and count of entries in use.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cap_q  <= lkv_pkg::CAP_BITS'(lkv_pkg::CAP_RESET);
			used_q <= '0;
		end else begin
			if (cfg_we) begin
				cap_q <= cfg_wdata;
			end
			if (accept && is_put && !any_hit && !need_evict) begin
				used_q <= used_q + CW'(1);
			end
		end
	end

	// Result valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid_q <= 1'b0;
		end else if (accept) begin
			m_tvalid_q <= 1'b1;
		end else if (m_tready) begin
			m_tvalid_q <= 1'b0;
		end
	end

	// Result payload, loaded with each accepted item.
	always_ff @(posedge clk) begin
		if (accept) begin
			found_q       <= any_hit;
			read_value_q  <= (any_hit && !is_put) ? hit_value : '0;
			evicted_q     <= need_evict;
			evicted_key_q <= need_evict ? entries[victim_idx].key : '0;
		end
	end

	assign m_tvalid = m_tvalid_q;
	assign m_tdata  = {evicted_key_q, read_value_q};
	assign m_tuser  = {evicted_q, found_q};

	// At most one cell may match a key.
	a_single_hit: assert property (@(posedge clk) disable iff (!arst_n)
		$onehot0(hit_vec))
		else $error("more than one cell matched the key");

	// Valid cells form an unbroken run from the head of the row.
	a_valid_packed: assert property (@(posedge clk) disable iff (!arst_n)
		(valid_vec & (valid_vec + N'(1))) == '0)
		else $error("valid cells are not contiguous");

	// The use count matches the number of valid cells.
	a_used_count: assert property (@(posedge clk) disable iff (!arst_n)
		$countones(valid_vec) == int'(used_q))
		else $error("use count disagrees with valid cells");

	// An eviction never goes with a hit.
	a_evict_no_hit: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid_q |-> !(found_q && evicted_q))
		else $error("eviction reported together with a hit");

endmodule

### hw/rtl/lkv_cell.sv
// One cell of the recency chain: holds an entry and compares its key.
// Depends on lkv_pkg for the entry type and field widths.
module lkv_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          shift,
	input  lkv_pkg::entry_t               left,
	input  logic [lkv_pkg::KEY_BITS-1:0]  lookup_key,
	output lkv_pkg::entry_t               entry,
	output logic                          hit
);

	logic                           valid_q;
	logic [lkv_pkg::KEY_BITS-1:0]   key_q;
	logic [lkv_pkg::VALUE_BITS-1:0] value_q;

	// The valid bit is control state and clears at reset.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (shift) begin
			valid_q <= left.valid;
		end
	end

	// Key and value take the left neighbor's entry when the chain shifts.
	always_ff @(posedge clk) begin
		if (shift) begin
			key_q   <= left.key;
			value_q <= left.value;
		end
	end

	// A valid entry whose key equals the lookup key is a hit.
	assign hit = valid_q && (key_q == lookup_key);

	assign entry.valid = valid_q;
	assign entry.key   = key_q;
	assign entry.value = value_q;

endmodule

### test/lru_key_value_cache_top_tb.sv
// Self-checking testbench for the LRU key-value cache top level.
// Depends on lkv_pkg and lru_key_value_cache_top; predicts every reply in place.
`timescale 1ns / 1ps

module lru_key_value_cache_top_tb;

	localparam int ENTRIES    = lkv_pkg::ENTRIES;
	localparam int KEY_BITS   = lkv_pkg::KEY_BITS;
	localparam int VALUE_BITS = lkv_pkg::VALUE_BITS;

	localparam int WATCHDOG_LIMIT = 1000;
	localparam int MAX_GAP        = 13;
	localparam int POOL_MAX       = 32;

	// One reply as the cache should return it.
	typedef struct packed {
		logic                  found;
		logic [VALUE_BITS-1:0] read_value;
		logic                  evicted;
		logic [KEY_BITS-1:0]   evicted_key;
	} reply_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [4:0]  cfg_wdata;
	logic        s_tvalid;
	logic        s_tready;
	logic [31:0] s_tdata;     // key [15:0], value [31:16]
	logic [0:0]  s_tuser;     // action [0]
	logic        m_tvalid;
	logic        m_tready;
	logic [31:0] m_tdata;     // read_value [15:0], evicted_key [31:16]
	logic [1:0]  m_tuser;     // found [0], evicted [1]

	// Shadow copy of the cache contents and its recency ranks, 0 most recent.
	logic                  shadow_valid [ENTRIES];
	logic [KEY_BITS-1:0]   shadow_key   [ENTRIES];
	logic [VALUE_BITS-1:0] shadow_value [ENTRIES];
	int                    shadow_rank  [ENTRIES];
	int                    shadow_used;
	logic [4:0]            shadow_capacity;

	reply_t due_replies [$];
	reply_t want;

	logic [KEY_BITS-1:0] key_pool [POOL_MAX];
	int  pool_size;
	bit  idle_on;
	int  errors;
	int  requests_sent;
	int  hit_count;
	int  evict_count;
	int  settings_count;
	int  quiet_cycles;

	lru_key_value_cache_top i_dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.s_tvalid  (s_tvalid),
		.s_tready  (s_tready),
		.s_tdata   (s_tdata),
		.s_tuser   (s_tuser),
		.m_tvalid  (m_tvalid),
		.m_tready  (m_tready),
		.m_tdata   (m_tdata),
		.m_tuser   (m_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Cycles to wait before the next item on either side.
	function automatic int draw_gap();
		if (!idle_on)
			return 0;
		return $urandom_range(0, MAX_GAP);
	endfunction

	// Move one entry to the front; younger valid entries age by one.
	function automatic void promote(input int idx);
		int i;
		for (i = 0; i < ENTRIES; i++)
			if (shadow_valid[i] && i != idx && shadow_rank[i] < shadow_rank[idx])
				shadow_rank[i]++;
		shadow_rank[idx] = 0;
	endfunction

	// Apply one get or put to the shadow cache and return the reply it causes.
	function automatic reply_t lru_lookup(input logic act, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		reply_t r;
		int     hit;
		int     victim;
		int     slot;
		int     cap;
		int     i;
		r = '0;
		hit = -1;
		victim = -1;
		slot = -1;
		for (i = 0; i < ENTRIES; i++)
			if (hit < 0 && shadow_valid[i] && shadow_key[i] == k)
				hit = i;
		if (hit >= 0) begin
			r.found = 1'b1;
			if (act == lkv_pkg::ACT_GET)
				r.read_value = shadow_value[hit];
			else
				shadow_value[hit] = v;
			promote(hit);
			return r;
		end
		if (act == lkv_pkg::ACT_GET)
			return r;

		// Zero acts as one, and anything above the built size saturates.
		cap = (shadow_capacity == 0) ? 1 : int'(shadow_capacity);
		if (cap > ENTRIES)
			cap = ENTRIES;
		if (shadow_used >= cap) begin
			for (i = 0; i < ENTRIES; i++)
				if (shadow_valid[i] && (victim < 0 || shadow_rank[i] > shadow_rank[victim]))
					victim = i;
			if (victim >= 0) begin
				r.evicted = 1'b1;
				r.evicted_key = shadow_key[victim];
				shadow_valid[victim] = 1'b0;
				shadow_rank[victim] = 0;
				shadow_used--;
			end
		end

		for (i = 0; i < ENTRIES; i++)
			if (slot < 0 && !shadow_valid[i])
				slot = i;
		if (slot >= 0) begin
			for (i = 0; i < ENTRIES; i++)
				if (shadow_valid[i])
					shadow_rank[i]++;
			shadow_valid[slot] = 1'b1;
			shadow_key[slot] = k;
			shadow_value[slot] = v;
			shadow_rank[slot] = 0;
			shadow_used++;
		end
		return r;
	endfunction

	// Send one request and record the reply it should produce once accepted.
	// The valid stays high afterwards so that back-to-back items need no toggle.
	task automatic send_request(input logic act, input logic [KEY_BITS-1:0] k,
			input logic [VALUE_BITS-1:0] v);
		int     gap;
		reply_t r;
		gap = draw_gap();
		if (gap > 0) begin
			s_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		s_tvalid <= 1'b1;
		s_tuser  <= act;
		s_tdata  <= {v, k};
		do
			@(posedge clk);
		while (!s_tready);
		r = lru_lookup(act, k, v);
		due_replies.push_back(r);
		requests_sent++;
		if (r.found && act == lkv_pkg::ACT_GET)
			hit_count++;
		if (r.evicted)
			evict_count++;
	endtask

	// Stop sending, let every pending reply come back, then a short pause.
	task automatic settle();
		s_tvalid <= 1'b0;
		while (due_replies.size() != 0)
			@(posedge clk);
		repeat (3) @(posedge clk);
	endtask

	task automatic write_capacity(input logic [4:0] cap);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= cap;
		@(posedge clk);
		cfg_we <= 1'b0;
		shadow_capacity = cap;
		settings_count++;
	endtask

	// Pick a fresh set of keys so that random traffic hits often.
	task automatic fill_key_pool(input int n);
		int i;
		pool_size = n;
		for (i = 0; i < n; i++)
			key_pool[i] = KEY_BITS'($urandom);
	endtask

	// Random gets and puts, mostly on pooled keys, some on any key at all.
	task automatic run_traffic(input int count);
		int          n;
		logic [KEY_BITS-1:0] k;
		logic        act;
		for (n = 0; n < count; n++) begin
			if ($urandom_range(0, 29) == 0)
				idle_on = !idle_on;
			if ($urandom_range(0, 99) < 85)
				k = key_pool[$urandom_range(0, pool_size - 1)];
			else
				k = KEY_BITS'($urandom);
			act = $urandom_range(0, 1) ? lkv_pkg::ACT_PUT : lkv_pkg::ACT_GET;
			send_request(act, k, VALUE_BITS'($urandom));
		end
		settle();
	endtask

	// Miss on an empty cache, extreme keys and values, overwrite of a present key.
	task automatic test_basic_ops();
		send_request(lkv_pkg::ACT_GET, 16'h0000, 16'hFFFF);
		send_request(lkv_pkg::ACT_PUT, 16'h0000, 16'h0000);
		send_request(lkv_pkg::ACT_PUT, 16'hFFFF, 16'hFFFF);
		send_request(lkv_pkg::ACT_GET, 16'h0000, 16'h0000);
		send_request(lkv_pkg::ACT_GET, 16'hFFFF, 16'h0000);
		send_request(lkv_pkg::ACT_PUT, 16'hFFFF, 16'h1234);
		send_request(lkv_pkg::ACT_GET, 16'hFFFF, 16'hFFFF);
		send_request(lkv_pkg::ACT_GET, 16'h8000, 16'h0000);
		settle();
	endtask

	// With room for two, a get refreshes its entry so the other one goes.
	task automatic test_eviction_order();
		write_capacity(5'd2);
		send_request(lkv_pkg::ACT_PUT, 16'h00A1, 16'h5555);
		send_request(lkv_pkg::ACT_PUT, 16'h00B2, 16'hAAAA);
		send_request(lkv_pkg::ACT_GET, 16'h00A1, 16'h0000);
		send_request(lkv_pkg::ACT_PUT, 16'h00C3, 16'h0F0F);
		send_request(lkv_pkg::ACT_GET, 16'h00B2, 16'h0000);
		send_request(lkv_pkg::ACT_GET, 16'h00A1, 16'h0000);
		settle();
	endtask

	// A capacity of zero behaves as a capacity of one.
	task automatic test_capacity_zero();
		write_capacity(5'd0);
		send_request(lkv_pkg::ACT_PUT, 16'h7FFF, 16'h8001);
		send_request(lkv_pkg::ACT_PUT, 16'h0001, 16'h7FFE);
		send_request(lkv_pkg::ACT_GET, 16'h7FFF, 16'h0000);
		send_request(lkv_pkg::ACT_GET, 16'h0001, 16'h0000);
		settle();
	endtask

	// The largest register value saturates to the built entry count.
	task automatic test_capacity_saturated();
		write_capacity(5'd31);
		fill_key_pool(24);
		run_traffic(80);
	endtask

	// Dropping the capacity below current use evicts only on inserts.
	task automatic test_capacity_lowered();
		write_capacity(5'd3);
		fill_key_pool(8);
		run_traffic(70);
		write_capacity(5'd1);
		fill_key_pool(4);
		run_traffic(60);
	endtask

	// Full capacity, then a few random settings across the whole register range.
	task automatic test_random_capacities();
		int p;
		write_capacity(5'd16);
		fill_key_pool(20);
		run_traffic(80);
		for (p = 0; p < 3; p++) begin
			write_capacity(5'($urandom_range(0, 31)));
			fill_key_pool($urandom_range(2, POOL_MAX));
			run_traffic(60);
		end
	endtask

	// Receiver side: a random stall before each item it takes.
	initial begin : result_sink
		int gap;
		m_tready <= 1'b0;
		forever begin
			gap = draw_gap();
			if (gap > 0) begin
				m_tready <= 1'b0;
				repeat (gap) @(posedge clk);
			end
			m_tready <= 1'b1;
			do
				@(posedge clk);
			while (!(m_tvalid && m_tready));
		end
	end

	task automatic check_field(input string name, input logic [15:0] exp_val,
			input logic [15:0] act_val);
		if (act_val !== exp_val) begin
			$display("%0t: %s mismatch, expected %h actual %h", $time, name, exp_val, act_val);
			errors++;
		end
	endtask

	// Compare each reply with the oldest one predicted.
	always @(posedge clk) begin
		if (m_tvalid && m_tready) begin
			if (due_replies.size() == 0) begin
				$display("%0t: unexpected reply, expected none actual tdata %h tuser %h",
					$time, m_tdata, m_tuser);
				errors++;
			end else begin
				want = due_replies.pop_front();
				check_field("found", 16'(want.found), 16'(m_tuser[0]));
				check_field("read_value", want.read_value, m_tdata[15:0]);
				check_field("evicted", 16'(want.evicted), 16'(m_tuser[1]));
				check_field("evicted_key", want.evicted_key, m_tdata[31:16]);
			end
		end
	end

	// Watchdog: too long without any item moving ends the run.
	always @(posedge clk) begin
		if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles >= WATCHDOG_LIMIT) begin
			$display("%0t: no item moved for %0d cycles, %0d replies pending",
				$time, WATCHDOG_LIMIT, due_replies.size());
			$display("tb: failure");
			$finish;
		end
	end

	initial begin : main_sequence
		int i;
		arst_n    <= 1'b0;
		cfg_we    <= 1'b0;
		cfg_wdata <= '0;
		s_tvalid  <= 1'b0;
		s_tdata   <= '0;
		s_tuser   <= lkv_pkg::ACT_GET;
		quiet_cycles <= 0;
		idle_on = 1'b1;
		errors = 0;
		requests_sent = 0;
		hit_count = 0;
		evict_count = 0;
		settings_count = 1;
		pool_size = 1;
		shadow_capacity = 5'(lkv_pkg::CAP_RESET);
		shadow_used = 0;
		for (i = 0; i < ENTRIES; i++) begin
			shadow_valid[i] = 1'b0;
			shadow_key[i]   = '0;
			shadow_value[i] = '0;
			shadow_rank[i]  = 0;
		end
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_basic_ops();
		test_eviction_order();
		test_capacity_zero();
		test_capacity_saturated();
		test_capacity_lowered();
		test_random_capacities();
		settle();

		$display("Ran %0d requests over %0d capacity settings: %0d get hits, %0d evictions.",
			requests_sent, settings_count, hit_count, evict_count);
		if (errors == 0) begin
			$display("tb: success");
		end else begin
			$display("%0d mismatches found.", errors);
			$display("tb: failure");
		end
		$finish;
	end

endmodule
